// ----- sv/dudc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dudc_pkg
// Shared types, constants and the seven-segment table of the debounced
// up/down counter with multiplexed display.
// ----------------------------------------------------------------------------
package dudc_pkg;

   localparam int unsigned NumDigits = 3;
   localparam int unsigned PtrWidth  = 2;

   // register indexes of the csr port
   localparam logic [1:0] CsrShortThreshold = 2'd0;
   localparam logic [1:0] CsrLongThreshold  = 2'd1;
   localparam logic [1:0] CsrCountMax       = 2'd2;
   localparam logic [1:0] CsrCommonCathode  = 2'd3;

   localparam logic [15:0] ShortThresholdReset = 16'd1000;
   localparam logic [15:0] LongThresholdReset  = 16'd3000;
   localparam logic [7:0]  CountMaxReset       = 8'd100;
   localparam logic        CommonCathodeReset  = 1'b0;

   // thresholds seen by every debouncer
   typedef struct packed {
      logic [15:0] short_threshold;
      logic [15:0] long_threshold;
   } thr_type;

   // hex seven-segment patterns, bit7 a down to bit1 g, bit0 dot
   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      unique case (digit)
         4'h0: pat = 8'b11111100;
         4'h1: pat = 8'b01100000;
         4'h2: pat = 8'b11011010;
         4'h3: pat = 8'b11110010;
         4'h4: pat = 8'b01100110;
         4'h5: pat = 8'b10110110;
         4'h6: pat = 8'b10111110;
         4'h7: pat = 8'b11100000;
         4'h8: pat = 8'b11111110;
         4'h9: pat = 8'b11110110;
         4'hA: pat = 8'b11101110;
         4'hB: pat = 8'b00111110;
         4'hC: pat = 8'b10011100;
         4'hD: pat = 8'b01111010;
         4'hE: pat = 8'b10011110;
         4'hF: pat = 8'b10001110;
         default: pat = 8'b00000000;
      endcase
      return pat;
   endfunction

endpackage

// ----- sv/dudc_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dudc_req_if
// Request channel: the three button levels of one tick.
// ----------------------------------------------------------------------------
interface dudc_req_if;
   logic valid;
   logic ready;
   logic increase_level;
   logic decrease_level;
   logic clear_level;

   modport source (output valid, output increase_level, output decrease_level,
                   output clear_level, input ready);
   modport sink (input valid, input increase_level, input decrease_level,
                 input clear_level, output ready);
endinterface

// ----- sv/dudc_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dudc_rsp_if
// Result channel: segment pattern, digit enable and counter value.
// ----------------------------------------------------------------------------
interface dudc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] segments;
   logic [2:0] digit_enable;
   logic [7:0] count_value;

   modport source (output valid, output segments, output digit_enable,
                   output count_value, input ready);
   modport sink (input valid, input segments, input digit_enable,
                 input count_value, output ready);
endinterface

// ----- sv/debounced_up_down_counter_display.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_up_down_counter_display
// Debounced up/down counter driving a multiplexed three-digit display.
// ----------------------------------------------------------------------------
// Each request is one tick of three button levels and gives exactly one
// result. A request enters an input register; from there the three
// debouncers, the counter update and the digit encoder settle in one pass and
// load the result register. The block takes one request every cycle and holds
// a request only while the result register is full and not being taken, so
// the throughput is one request per cycle while results are taken. Clear
// beats increase, increase beats decrease; a button below one that fires keeps
// its state for that tick. Configuration must be written through the csr
// port while no request is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module debounced_up_down_counter_display (
   input  logic        clock,
   input  logic        reset,
   dudc_req_if.sink    req_ch,
   dudc_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import dudc_pkg::*;

   // configuration
   thr_type             thr_ff;
   logic [7:0]          count_max_ff;
   logic                common_cathode_ff;

   // input register
   logic                s1_valid_ff;
   logic                inc_ff, dec_ff, clr_ff;

   // block state
   logic [7:0]          count_ff, count_in;
   logic [PtrWidth-1:0] ptr_ff, ptr_in;

   // result register
   logic                rsp_valid_ff;
   logic [7:0]          seg_ff, seg_in;
   logic [2:0]          den_ff, den_in;
   logic [7:0]          cnt_out_ff;

   logic                advance;
   logic                clr_fire, inc_fire, dec_fire;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.short_threshold <= ShortThresholdReset;
         thr_ff.long_threshold  <= LongThresholdReset;
         count_max_ff           <= CountMaxReset;
         common_cathode_ff      <= CommonCathodeReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrShortThreshold: thr_ff.short_threshold <= csr_wdata;
            CsrLongThreshold:  thr_ff.long_threshold  <= csr_wdata;
            CsrCountMax:       count_max_ff           <= csr_wdata[7:0];
            CsrCommonCathode:  common_cathode_ff      <= csr_wdata[0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         inc_ff <= req_ch.increase_level;
         dec_ff <= req_ch.decrease_level;
         clr_ff <= req_ch.clear_level;
      end
   end

   dudc_debounce #(.REPEAT(1'b0)) u_clr (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .level  (clr_ff),
      .thr    (thr_ff),
      .fire   (clr_fire)
   );

   dudc_debounce #(.REPEAT(1'b1)) u_inc (
      .clock  (clock),
      .reset  (reset),
      .enable (advance && !clr_fire),
      .level  (inc_ff),
      .thr    (thr_ff),
      .fire   (inc_fire)
   );

   dudc_debounce #(.REPEAT(1'b1)) u_dec (
      .clock  (clock),
      .reset  (reset),
      .enable (advance && !clr_fire && !inc_fire),
      .level  (dec_ff),
      .thr    (thr_ff),
      .fire   (dec_fire)
   );

   always_comb begin
      priority if (clr_fire) begin
         count_in = 8'd0;
      end else if (inc_fire) begin
         count_in = (count_ff >= count_max_ff) ? 8'd0 : count_ff + 8'd1;
      end else if (dec_fire) begin
         count_in = (count_ff != 8'd0) ? count_ff - 8'd1 : count_max_ff;
      end else begin
         count_in = count_ff;
      end
   end

   dudc_display u_display (
      .common_cathode (common_cathode_ff),
      .count          (count_in),
      .ptr            (ptr_ff),
      .ptr_next       (ptr_in),
      .segments       (seg_in),
      .digit_enable   (den_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 8'd0;
         ptr_ff   <= '0;
      end else if (advance) begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         seg_ff     <= seg_in;
         den_ff     <= den_in;
         cnt_out_ff <= count_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.segments     = seg_ff;
   assign rsp_ch.digit_enable = den_ff;
   assign rsp_ch.count_value  = cnt_out_ff;

endmodule

// ----- sv/dudc_debounce.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dudc_debounce
// Debounce counter for one button. Reports a press on release, and with
// auto-repeat enabled also after a long hold. State only moves on enable.
// ----------------------------------------------------------------------------
module dudc_debounce #(
   parameter bit REPEAT = 1'b1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              level,
   input  dudc_pkg::thr_type thr,
   output logic              fire
);
   import dudc_pkg::*;

   logic [15:0] cnt_ff, cnt_in;
   logic        pressed_ff, pressed_in;
   logic        pending_ff, pending_in;
   logic [15:0] bump;

   assign bump = (cnt_ff == 16'hFFFF) ? cnt_ff : cnt_ff + 16'd1;

   always_comb begin
      cnt_in     = cnt_ff;
      pressed_in = pressed_ff;
      pending_in = pending_ff;
      fire       = 1'b0;
      priority if (level && !pressed_ff) begin
         if (cnt_ff > thr.short_threshold) begin
            pressed_in = 1'b1;
            cnt_in     = 16'd0;
         end else begin
            cnt_in = bump;
         end
      end else if (!level && pressed_ff) begin
         if (REPEAT && pending_ff) begin
            // restart the release count: zero never beats the threshold
            pending_in = 1'b0;
            cnt_in     = 16'd1;
         end else if (cnt_ff > thr.short_threshold) begin
            pressed_in = 1'b0;
            cnt_in     = 16'd0;
            fire       = 1'b1;
         end else begin
            cnt_in = bump;
         end
      end else if (level && pressed_ff && REPEAT) begin
         pending_in = 1'b1;
         if (cnt_ff >= thr.long_threshold) begin
            pressed_in = 1'b0;
            pending_in = 1'b0;
            cnt_in     = 16'd0;
            fire       = 1'b1;
         end else begin
            cnt_in = bump;
         end
      end else begin
         if (REPEAT) begin
            pending_in = 1'b0;
         end
         cnt_in = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= 16'd0;
         pressed_ff <= 1'b0;
         pending_ff <= 1'b0;
      end else if (enable) begin
         cnt_ff     <= cnt_in;
         pressed_ff <= pressed_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// ----- sv/dudc_display.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dudc_display
// Splits the counter into decimal digits and drives the digit chosen by the
// rotation pointer through the seven-segment table.
// ----------------------------------------------------------------------------
module dudc_display (
   input  logic                          common_cathode,
   input  logic [7:0]                    count,
   input  logic [dudc_pkg::PtrWidth-1:0] ptr,
   output logic [dudc_pkg::PtrWidth-1:0] ptr_next,
   output logic [7:0]                    segments,
   output logic [2:0]                    digit_enable
);
   import dudc_pkg::*;

   logic [1:0]          hundreds;
   logic [7:0]          rem;
   logic [15:0]         tens_prod;
   logic [3:0]          tens;
   logic [3:0]          units;
   logic [7:0]          tens_x10;
   logic [PtrWidth-1:0] p;
   logic [3:0]          digit;
   logic [7:0]          pat;

   always_comb begin
      if (count >= 8'd200) begin
         hundreds = 2'd2;
         rem      = count - 8'd200;
      end else if (count >= 8'd100) begin
         hundreds = 2'd1;
         rem      = count - 8'd100;
      end else begin
         hundreds = 2'd0;
         rem      = count;
      end
   end

   // divide by ten through the reciprocal 205/2048, exact below 100
   assign tens_prod = {8'd0, rem} * 16'd205;
   assign tens      = tens_prod[14:11];
   assign tens_x10  = {4'd0, tens} * 8'd10;
   assign units     = 4'(rem - tens_x10);

   // out-of-range pointer falls back to the units digit
   assign p        = (ptr >= PtrWidth'(NumDigits)) ? '0 : ptr;
   assign ptr_next = (p == PtrWidth'(NumDigits - 1)) ? '0 : p + PtrWidth'(1);

   always_comb begin
      unique case (p)
         2'd1:    digit = tens;
         2'd2:    digit = {2'd0, hundreds};
         default: digit = units;
      endcase
   end

   assign pat          = seg_pattern(digit);
   assign segments     = common_cathode ? pat : ~pat;
   assign digit_enable = 3'(3'b001 << p);

endmodule
